### src/robin_hood_hash_table_macros.svh
// Assertion macros used by the hash table top level.
`ifndef ROBIN_HOOD_HASH_TABLE_MACROS_SVH
`define ROBIN_HOOD_HASH_TABLE_MACROS_SVH

// Checked on every clock edge outside reset.
`define RHH_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define RHH_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

### src/rhh_pkg.sv
// Shared types and constants of the Robin Hood hash table.
`timescale 1ns / 1ps
`default_nettype none

package rhh_pkg;

    localparam int SLOTS_DEF    = 256;
    localparam int KEY_BITS_DEF = 64;
    localparam int CFG_W        = 9;
    localparam int HASH_W       = 32;
    localparam int KEY_W        = 64;
    localparam int VAL_W        = 32;
    localparam int CNT_W        = 9;
    localparam logic [CFG_W-1:0] CFG_RESET = 9'd256;

    typedef enum logic [1:0] {
        FUNC_GET = 2'd0,
        FUNC_PUT = 2'd1,
        FUNC_DEL = 2'd2,
        FUNC_NOP = 2'd3
    } func_t;

    typedef enum logic [2:0] {
        ST_INSERTED = 3'd0,
        ST_UPDATED  = 3'd1,
        ST_FOUND    = 3'd2,
        ST_MISSING  = 3'd3,
        ST_FULL     = 3'd4
    } status_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_MOD,
        S_LOOK,
        S_FREE,
        S_PLACE,
        S_DEL,
        S_DELEND,
        S_RESP
    } state_t;

    typedef struct packed {
        status_t            status;
        logic [VAL_W-1:0]   value;
    } result_t;

endpackage

`default_nettype wire

### src/rhh_mod.sv
// Bit-serial unit that reduces a 32-bit hash modulo the slot count.
`timescale 1ns / 1ps
`default_nettype none

module rhh_mod
    import rhh_pkg::*;
#(
    parameter int NW = 9
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              start,
    input  wire logic [HASH_W-1:0] dividend,
    input  wire logic [NW-1:0]     divisor,
    output logic                   done,
    output logic [NW-1:0]          rem
);

    logic [HASH_W-1:0] quo_reg, quo_next;
    logic [NW-1:0]     rem_reg, rem_next;
    logic [4:0]        cnt_reg, cnt_next;
    logic              run_reg, run_next;
    logic              done_reg, done_next;
    logic [NW:0]       trial;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    always_comb begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        trial     = {rem_reg, quo_reg[HASH_W-1]};
        if (start) begin
            quo_next = dividend;
            rem_next = '0;
            cnt_next = '0;
            run_next = 1'b1;
        end else if (run_reg) begin
            // One restoring step per cycle; the remainder stays below the divisor.
            if (trial >= {1'b0, divisor}) begin
                rem_next = NW'(trial - {1'b0, divisor});
            end else begin
                rem_next = trial[NW-1:0];
            end
            quo_next = {quo_reg[HASH_W-2:0], 1'b0};
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'd31) begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    assign done = done_reg;
    assign rem  = rem_reg;

endmodule

`default_nettype wire

### src/rhh_mem.sv
// Slot memory: one write port, one read port with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module rhh_mem
    import rhh_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF,
    parameter int SW    = 8,
    parameter int DW    = 137
) (
    input  wire logic          aclk,
    input  wire logic          we,
    input  wire logic [SW-1:0] waddr,
    input  wire logic [DW-1:0] wdata,
    input  wire logic [SW-1:0] raddr,
    output logic [DW-1:0]      rdata
);

    logic [DW-1:0] mem [SLOTS];
    logic [DW-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

### src/rhh_engine.sv
// Probe sequencer: lookup, Robin Hood insert and backward-shift delete.
`timescale 1ns / 1ps
`default_nettype none

module rhh_engine
    import rhh_pkg::*;
#(
    parameter int SLOTS    = SLOTS_DEF,
    parameter int KEY_BITS = KEY_BITS_DEF
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic [$clog2(SLOTS+1)-1:0]      n_eff,
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire func_t                           in_func,
    input  wire logic [HASH_W-1:0]               in_hash,
    input  wire logic [KEY_W-1:0]                in_key,
    input  wire logic [VAL_W-1:0]                in_val,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output result_t                              out_res,
    output logic [CNT_W-1:0]                     out_count
);

    localparam int SW = $clog2(SLOTS);
    localparam int NW = $clog2(SLOTS+1);
    localparam int CW = $clog2(SLOTS+1);
    localparam int DW = 1 + SW + HASH_W + KEY_BITS + VAL_W;
    localparam logic [SW-1:0] LAST_SLOT = SW'(SLOTS - 1);

    state_t                state_reg, state_next;
    func_t                 func_reg, func_next;
    logic [HASH_W-1:0]     hash_reg, hash_next;
    logic [KEY_BITS-1:0]   key_reg, key_next;
    logic [VAL_W-1:0]      val_reg, val_next;
    logic [SW-1:0]         pos_reg, pos_next;
    logic [SW-1:0]         hole_reg, hole_next;
    logic [SW-1:0]         start_reg, start_next;
    logic [SW-1:0]         dist_reg, dist_next;
    logic [NW-1:0]         left_reg, left_next;
    logic [SW-1:0]         clr_reg, clr_next;
    logic [CW-1:0]         count_reg, count_next;
    status_t               stat_reg, stat_next;
    logic [VAL_W-1:0]      vout_reg, vout_next;
    logic                  ovalid_reg, ovalid_next;
    result_t               ores_reg, ores_next;
    logic [CNT_W-1:0]      ocount_reg, ocount_next;

    logic                  mod_start, mod_done;
    logic [NW-1:0]         mod_rem;
    logic                  mod_busy_reg;

    logic                  we;
    logic [SW-1:0]         waddr;
    logic [DW-1:0]         wdata;
    logic [DW-1:0]         rdata;

    logic                  r_used;
    logic [SW-1:0]         r_dist;
    logic [HASH_W-1:0]     r_hash;
    logic [KEY_BITS-1:0]   r_key;
    logic [VAL_W-1:0]      r_val;
    logic [NW-1:0]         pos_p1;
    logic [SW-1:0]         pos_inc;
    logic                  stop_miss, hit, last;

    rhh_mod #(
        .NW(NW)
    ) u_mod (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (mod_start),
        .dividend (hash_reg),
        .divisor  (n_eff),
        .done     (mod_done),
        .rem      (mod_rem)
    );

    // Read address follows the next probe position, so read data always
    // belongs to the slot at pos_reg.
    rhh_mem #(
        .SLOTS(SLOTS),
        .SW   (SW),
        .DW   (DW)
    ) u_mem (
        .aclk  (aclk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (pos_next),
        .rdata (rdata)
    );

    assign r_val  = rdata[VAL_W-1:0];
    assign r_key  = rdata[VAL_W +: KEY_BITS];
    assign r_hash = rdata[VAL_W+KEY_BITS +: HASH_W];
    assign r_dist = rdata[VAL_W+KEY_BITS+HASH_W +: SW];
    assign r_used = rdata[DW-1];

    assign pos_p1  = NW'(pos_reg) + NW'(1);
    assign pos_inc = (pos_p1 == n_eff) ? '0 : pos_p1[SW-1:0];

    assign stop_miss = !r_used || (r_dist < dist_reg);
    assign hit       = !stop_miss && (r_hash == hash_reg) && (r_key == key_reg);
    assign last      = (NW'(dist_reg) + NW'(1)) == n_eff;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_CLEAR;
            clr_reg    <= '0;
            count_reg  <= '0;
            ovalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            clr_reg    <= clr_next;
            count_reg  <= count_next;
            ovalid_reg <= ovalid_next;
        end
        func_reg   <= func_next;
        hash_reg   <= hash_next;
        key_reg    <= key_next;
        val_reg    <= val_next;
        pos_reg    <= pos_next;
        hole_reg   <= hole_next;
        start_reg  <= start_next;
        dist_reg   <= dist_next;
        left_reg   <= left_next;
        stat_reg   <= stat_next;
        vout_reg   <= vout_next;
        ores_reg   <= ores_next;
        ocount_reg <= ocount_next;
    end

    always_comb begin
        state_next  = state_reg;
        func_next   = func_reg;
        hash_next   = hash_reg;
        key_next    = key_reg;
        val_next    = val_reg;
        pos_next    = pos_reg;
        hole_next   = hole_reg;
        start_next  = start_reg;
        dist_next   = dist_reg;
        left_next   = left_reg;
        clr_next    = clr_reg;
        count_next  = count_reg;
        stat_next   = stat_reg;
        vout_next   = vout_reg;
        ovalid_next = ovalid_reg;
        ores_next   = ores_reg;
        ocount_next = ocount_reg;
        in_ready    = 1'b0;
        mod_start   = 1'b0;
        we          = 1'b0;
        waddr       = pos_reg;
        wdata       = {1'b1, dist_reg, hash_reg, key_reg, val_reg};

        if (ovalid_reg && out_ready) begin
            ovalid_next = 1'b0;
        end

        case (state_reg)
            S_CLEAR: begin
                we       = 1'b1;
                waddr    = clr_reg;
                wdata    = '0;
                clr_next = clr_reg + SW'(1);
                if (clr_reg == LAST_SLOT) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    func_next = in_func;
                    hash_next = in_hash;
                    key_next  = in_key[KEY_BITS-1:0];
                    val_next  = in_val;
                    vout_next = '0;
                    if (in_func == FUNC_NOP) begin
                        stat_next  = ST_MISSING;
                        state_next = S_RESP;
                    end else begin
                        state_next = S_MOD;
                    end
                end
            end
            S_MOD: begin
                // The first cycle here starts the divider on the latched hash.
                mod_start = !mod_busy_reg;
                if (mod_done) begin
                    pos_next   = mod_rem[SW-1:0];
                    dist_next  = '0;
                    state_next = S_LOOK;
                end
            end
            S_LOOK: begin
                if (hit) begin
                    case (func_reg)
                        FUNC_GET: begin
                            stat_next  = ST_FOUND;
                            vout_next  = r_val;
                            state_next = S_RESP;
                        end
                        FUNC_PUT: begin
                            we         = 1'b1;
                            wdata      = {r_used, r_dist, r_hash, r_key, val_reg};
                            stat_next  = ST_UPDATED;
                            state_next = S_RESP;
                        end
                        FUNC_DEL: begin
                            if (count_reg != '0) begin
                                count_next = count_reg - CW'(1);
                            end
                            stat_next = ST_FOUND;
                            hole_next = pos_reg;
                            left_next = n_eff - NW'(1);
                            if (n_eff == NW'(1)) begin
                                state_next = S_DELEND;
                            end else begin
                                pos_next   = pos_inc;
                                state_next = S_DEL;
                            end
                        end
                        default: begin
                            stat_next  = ST_MISSING;
                            state_next = S_RESP;
                        end
                    endcase
                end else if (stop_miss) begin
                    if (func_reg == FUNC_PUT) begin
                        if (!r_used) begin
                            we         = 1'b1;
                            count_next = count_reg + CW'(1);
                            stat_next  = ST_INSERTED;
                            state_next = S_RESP;
                        end else if (last) begin
                            stat_next  = ST_FULL;
                            state_next = S_RESP;
                        end else begin
                            // Look for any empty slot in the rest of the ring
                            // before anything is displaced.
                            start_next = pos_reg;
                            left_next  = n_eff - NW'(dist_reg) - NW'(1);
                            pos_next   = pos_inc;
                            state_next = S_FREE;
                        end
                    end else begin
                        stat_next  = ST_MISSING;
                        state_next = S_RESP;
                    end
                end else if (last) begin
                    stat_next  = (func_reg == FUNC_PUT) ? ST_FULL : ST_MISSING;
                    state_next = S_RESP;
                end else begin
                    dist_next = dist_reg + SW'(1);
                    pos_next  = pos_inc;
                end
            end
            S_FREE: begin
                if (!r_used) begin
                    pos_next   = start_reg;
                    state_next = S_PLACE;
                end else if (left_reg == NW'(1)) begin
                    stat_next  = ST_FULL;
                    state_next = S_RESP;
                end else begin
                    left_next = left_reg - NW'(1);
                    pos_next  = pos_inc;
                end
            end
            S_PLACE: begin
                if (!r_used) begin
                    we         = 1'b1;
                    count_next = count_reg + CW'(1);
                    stat_next  = ST_INSERTED;
                    state_next = S_RESP;
                end else if (r_dist < dist_reg) begin
                    // Swap: the richer resident takes over as the carried entry.
                    we        = 1'b1;
                    hash_next = r_hash;
                    key_next  = r_key;
                    val_next  = r_val;
                    dist_next = r_dist + SW'(1);
                    pos_next  = pos_inc;
                end else begin
                    dist_next = dist_reg + SW'(1);
                    pos_next  = pos_inc;
                end
            end
            S_DEL: begin
                if (!r_used || (r_dist == '0)) begin
                    state_next = S_DELEND;
                end else begin
                    we        = 1'b1;
                    waddr     = hole_reg;
                    wdata     = {1'b1, r_dist - SW'(1), r_hash, r_key, r_val};
                    hole_next = pos_reg;
                    left_next = left_reg - NW'(1);
                    if (left_reg == NW'(1)) begin
                        state_next = S_DELEND;
                    end else begin
                        pos_next = pos_inc;
                    end
                end
            end
            S_DELEND: begin
                we         = 1'b1;
                waddr      = hole_reg;
                wdata      = '0;
                state_next = S_RESP;
            end
            S_RESP: begin
                if (!ovalid_reg || out_ready) begin
                    ovalid_next       = 1'b1;
                    ores_next.status  = stat_reg;
                    ores_next.value   = vout_reg;
                    ocount_next       = CNT_W'(count_reg);
                    state_next        = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mod_busy_reg <= 1'b0;
        end else if (state_reg == S_MOD) begin
            mod_busy_reg <= 1'b1;
        end else begin
            mod_busy_reg <= 1'b0;
        end
    end

    assign out_valid = ovalid_reg;
    assign out_res   = ores_reg;
    assign out_count = ocount_reg;

endmodule

`default_nettype wire

### src/robin_hood_hash_table.sv
// Flow: a transfer is taken in idle; a 32-step modulo of the hash gives the home slot,
// then slots are probed from there and the result is registered. Insert also scans for
// room and then walks the slots while placing; delete examines the slots after the hit
// and then clears the hole. func 3 goes straight to the result register.
// Throughput: one operation at a time; the next transfer is taken after the result is
// registered. Reset: synchronous, active low; a clearing pass then empties the slots.
`timescale 1ns / 1ps
`default_nettype none
`include "robin_hood_hash_table_macros.svh"

module robin_hood_hash_table
    import rhh_pkg::*;
#(
    parameter int SLOTS    = SLOTS_DEF,
    parameter int KEY_BITS = KEY_BITS_DEF
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              cfg_wr_en,
    input  wire logic [CFG_W-1:0]  cfg_wr_data,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [127:0]      s_tdata,   // hash[31:0], key[95:32], value[127:96]
    input  wire logic [1:0]        s_tuser,   // func[1:0]
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [47:0]            m_tdata,   // value_out[31:0], entry_count[40:32]
    output logic [2:0]             m_tuser    // status[2:0]
);

    localparam int NW = $clog2(SLOTS+1);

    logic [CFG_W-1:0] active_slots_reg;
    logic [NW-1:0]    n_eff;
    result_t          res;
    logic [CNT_W-1:0] count;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_slots_reg <= CFG_RESET;
        end else if (cfg_wr_en) begin
            active_slots_reg <= cfg_wr_data;
        end
    end

    // Zero acts as one slot and counts above the memory depth are clamped.
    always_comb begin
        if (active_slots_reg == '0) begin
            n_eff = NW'(1);
        end else if (32'(active_slots_reg) > SLOTS) begin
            n_eff = NW'(SLOTS);
        end else begin
            n_eff = NW'(active_slots_reg);
        end
    end

    rhh_engine #(
        .SLOTS   (SLOTS),
        .KEY_BITS(KEY_BITS)
    ) u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .n_eff     (n_eff),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_func   (func_t'(s_tuser)),
        .in_hash   (s_tdata[31:0]),
        .in_key    (s_tdata[95:32]),
        .in_val    (s_tdata[127:96]),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (res),
        .out_count (count)
    );

    assign m_tdata = {7'b0, count, res.value};
    assign m_tuser = res.status;

    `RHH_ASSERT(a_busy_after_accept, s_tvalid && s_tready |=> !s_tready, "input taken while busy")
    `RHH_ASSERT(a_value_only_on_get, m_tvalid && (m_tuser != ST_FOUND) |-> (m_tdata[31:0] == '0), "value without a hit")
    `RHH_ASSERT_ALWAYS(a_clear_after_reset, !aresetn |=> !s_tready, "input taken during clearing")

endmodule

`default_nettype wire
